// File: design/sdpg_pkg.sv
`timescale 1ns / 1ps

package sdpg_pkg;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_STOP      = 3'd2;
    localparam logic [2:0] OP_ABORT     = 3'd3;
    localparam logic [2:0] OP_SET_DIR   = 3'd4;
    localparam logic [2:0] OP_SET_FLAPS = 3'd5;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_STARTED   = 3'd1;
    localparam logic [2:0] EV_STOPPED   = 3'd2;
    localparam logic [2:0] EV_DIR_CHG   = 3'd3;
    localparam logic [2:0] EV_CLOSED    = 3'd4;
    localparam logic [2:0] EV_IN_OPEN   = 3'd5;
    localparam logic [2:0] EV_OUT_OPEN  = 3'd6;
    localparam logic [2:0] EV_EMERGENCY = 3'd7;

    localparam logic [1:0] PH_SAMPLE    = 2'd0;
    localparam logic [1:0] PH_STEP_LOW  = 2'd1;
    localparam logic [1:0] PH_STEP_HIGH = 2'd2;
    localparam logic [1:0] PH_BLOCKED   = 2'd3;

    localparam logic [1:0] FLAP_CLOSE_BOTH = 2'd0;
    localparam logic [1:0] FLAP_OPEN_IN    = 2'd1;
    localparam logic [1:0] FLAP_OPEN_OUT   = 2'd2;

    localparam logic [2:0] REG_HALF_PERIOD  = 3'd0;
    localparam logic [2:0] REG_BLOCKED_WAIT = 3'd1;
    localparam logic [2:0] REG_HOME_BIT     = 3'd2;
    localparam logic [2:0] REG_END_BIT      = 3'd3;
    localparam logic [2:0] REG_CLOSE_BOTH   = 3'd4;
    localparam logic [2:0] REG_OPEN_INPUT   = 3'd5;
    localparam logic [2:0] REG_OPEN_OUTPUT  = 3'd6;

    localparam int unsigned CFG_WIDTH = 24;

    localparam logic [7:0] STATUS_INV_MASK = 8'h80;

    typedef struct packed {
        logic home;
        logic lim_end;
    } t_lim;

endpackage

// File: design/sdpg_limits.sv
`timescale 1ns / 1ps

module sdpg_limits
    import sdpg_pkg::*;
(
    input  logic [7:0] i_status_byte,
    input  logic [2:0] i_home_bit,
    input  logic [2:0] i_end_bit,
    output t_lim       o_lim
);

    logic [7:0] status_fixed;

    // bit 7 of the status port arrives inverted
    assign status_fixed  = i_status_byte ^ STATUS_INV_MASK;
    assign o_lim.home    = status_fixed[i_home_bit];
    assign o_lim.lim_end = status_fixed[i_end_bit];

endmodule

// File: design/step_dir_pulse_generator_with_limits_unit.sv
`timescale 1ns / 1ps
// Stepper step/direction pulse generator with home and end limit switches.
// Input channel (i_in_valid / o_in_stall) carries one tick or command per
// transfer; output channel (o_out_valid / i_out_stall) returns exactly one
// result per input transfer, in order.
// An accepted item is held in the input register, then its result lands in
// the output register, which drives the outputs. Throughput is one item per
// clock while the receiver does not stall: the state update for an item is a
// single pass through the step/limit logic between the input register and
// the output register.
// When the receiver stalls, the result stays in the output register and the
// input register holds the next item; o_in_stall rises only when both are
// full, so no item is lost or repeated.
// Reset (synchronous, active low) clears both valid flags, returns the motor
// to idle in the sample phase, direction forward, published limits zero, and
// loads the configuration registers with their defaults.
// Configuration writes (i_cfg_we) take effect at the next edge; the user must
// make them only while the block is idle, as the block does not enforce this.

module step_dir_pulse_generator_with_limits_unit
    import sdpg_pkg::*;
#(
    parameter int COUNTER_WIDTH = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [CFG_WIDTH-1:0] i_cfg_wdata,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [2:0]           i_operation,
    input  logic [7:0]           i_status_byte,
    input  logic                 i_new_direction,
    input  logic [1:0]           i_flap_select,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_step_port_byte,
    output logic                 o_step_port_write,
    output logic [7:0]           o_flap_port_byte,
    output logic                 o_flap_port_write,
    output logic                 o_limit_home,
    output logic                 o_limit_end,
    output logic                 o_limits_changed,
    output logic                 o_is_running,
    output logic [2:0]           o_event_code
);

    // configuration
    logic [CFG_WIDTH-1:0] r_half_period;
    logic [CFG_WIDTH-1:0] r_blocked_wait;
    logic [2:0]           r_home_bit;
    logic [2:0]           r_end_bit;
    logic [7:0]           r_close_both;
    logic [7:0]           r_open_input;
    logic [7:0]           r_open_output;

    // input register
    logic       r_in_valid;
    logic [2:0] r_op;
    logic [7:0] r_status;
    logic       r_ndir;
    logic [1:0] r_fsel;

    // motion state
    logic                     r_run_mode,   n_run_mode;
    logic [1:0]               r_phase,      n_phase;
    logic [COUNTER_WIDTH-1:0] r_cnt,        n_cnt;
    logic                     r_dir,        n_dir;
    logic                     r_latched,    n_latched;
    logic [1:0]               r_pub,        n_pub;

    // output register
    logic       r_out_valid;
    logic [1:0] r_sbyte,   n_sbyte;
    logic       r_swrite,  n_swrite;
    logic [7:0] r_fbyte,   n_fbyte;
    logic       r_fwrite,  n_fwrite;
    logic       r_changed, n_changed;
    logic [2:0] r_event,   n_event;

    logic                     advance;
    logic                     in_take;
    t_lim                     lim;
    logic [1:0]               lim_bits;
    logic                     allowed;
    logic                     cnt_low;
    logic [COUNTER_WIDTH+CFG_WIDTH-1:0] half_ext;
    logic [COUNTER_WIDTH+CFG_WIDTH-1:0] wait_ext;
    logic [COUNTER_WIDTH-1:0] half_cnt;
    logic [COUNTER_WIDTH-1:0] wait_cnt;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !advance;

    sdpg_limits u_limits (
        .i_status_byte (r_status),
        .i_home_bit    (r_home_bit),
        .i_end_bit     (r_end_bit),
        .o_lim         (lim)
    );

    assign lim_bits = {lim.lim_end, lim.home};
    assign allowed  = r_dir ? !lim.home : !lim.lim_end;
    assign cnt_low  = (r_cnt[COUNTER_WIDTH-1:1] == '0);

    // fit the 24-bit registers to the counter width
    assign half_ext = {{COUNTER_WIDTH{1'b0}}, r_half_period};
    assign wait_ext = {{COUNTER_WIDTH{1'b0}}, r_blocked_wait};
    assign half_cnt = half_ext[COUNTER_WIDTH-1:0];
    assign wait_cnt = wait_ext[COUNTER_WIDTH-1:0];

    always_comb begin
        n_run_mode = r_run_mode;
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_dir      = r_dir;
        n_latched  = r_latched;
        n_pub      = r_pub;
        n_sbyte    = 2'b00;
        n_swrite   = 1'b0;
        n_fbyte    = 8'h00;
        n_fwrite   = 1'b0;
        n_changed  = 1'b0;
        n_event    = EV_NONE;
        case (r_op)
            OP_TICK: begin
                if (r_run_mode) begin
                    if (r_phase == PH_SAMPLE || (cnt_low && r_phase != PH_STEP_LOW)) begin
                        n_pub     = lim_bits;
                        n_changed = (lim_bits != r_pub);
                        if (!allowed) begin
                            n_phase = PH_BLOCKED;
                            n_cnt   = wait_cnt;
                        end else begin
                            n_latched = r_dir;
                            n_sbyte   = {r_dir, 1'b0};
                            n_swrite  = 1'b1;
                            n_phase   = PH_STEP_LOW;
                            n_cnt     = half_cnt;
                        end
                    end else if (cnt_low) begin
                        n_sbyte  = {r_latched, 1'b1};
                        n_swrite = 1'b1;
                        n_phase  = PH_STEP_HIGH;
                        n_cnt    = half_cnt;
                    end else begin
                        n_cnt = r_cnt - COUNTER_WIDTH'(1);
                    end
                end
            end
            OP_START: begin
                if (!r_run_mode) begin
                    n_run_mode = 1'b1;
                    n_phase    = PH_SAMPLE;
                    n_cnt      = '0;
                    n_event    = EV_STARTED;
                end
            end
            OP_STOP: begin
                if (r_run_mode) begin
                    n_run_mode = 1'b0;
                    n_phase    = PH_SAMPLE;
                    n_cnt      = '0;
                    n_event    = EV_STOPPED;
                end
            end
            OP_ABORT: begin
                n_pub      = lim_bits;
                n_changed  = (lim_bits != r_pub);
                n_run_mode = 1'b0;
                n_phase    = PH_SAMPLE;
                n_cnt      = '0;
                n_event    = EV_EMERGENCY;
            end
            OP_SET_DIR: begin
                if (r_ndir != r_dir) begin
                    n_dir   = r_ndir;
                    n_event = EV_DIR_CHG;
                end
            end
            OP_SET_FLAPS: begin
                case (r_fsel)
                    FLAP_CLOSE_BOTH: begin
                        n_fbyte  = r_close_both;
                        n_fwrite = 1'b1;
                        n_event  = EV_CLOSED;
                    end
                    FLAP_OPEN_IN: begin
                        n_fbyte  = r_open_input;
                        n_fwrite = 1'b1;
                        n_event  = EV_IN_OPEN;
                    end
                    FLAP_OPEN_OUT: begin
                        n_fbyte  = r_open_output;
                        n_fwrite = 1'b1;
                        n_event  = EV_OUT_OPEN;
                    end
                    default: begin
                        n_fwrite = 1'b0;
                    end
                endcase
            end
            default: begin
                n_event = EV_NONE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period  <= CFG_WIDTH'(1000);
            r_blocked_wait <= CFG_WIDTH'(25000);
            r_home_bit     <= 3'd0;
            r_end_bit      <= 3'd1;
            r_close_both   <= 8'h00;
            r_open_input   <= 8'h00;
            r_open_output  <= 8'h00;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HALF_PERIOD:  r_half_period  <= i_cfg_wdata;
                REG_BLOCKED_WAIT: r_blocked_wait <= i_cfg_wdata;
                REG_HOME_BIT:     r_home_bit     <= i_cfg_wdata[2:0];
                REG_END_BIT:      r_end_bit      <= i_cfg_wdata[2:0];
                REG_CLOSE_BOTH:   r_close_both   <= i_cfg_wdata[7:0];
                REG_OPEN_INPUT:   r_open_input   <= i_cfg_wdata[7:0];
                REG_OPEN_OUTPUT:  r_open_output  <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op     <= i_operation;
            r_status <= i_status_byte;
            r_ndir   <= i_new_direction;
            r_fsel   <= i_flap_select;
        end
    end

    // motion state moves with each transfer into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_mode <= 1'b0;
            r_phase    <= PH_SAMPLE;
            r_cnt      <= '0;
            r_dir      <= 1'b0;
            r_latched  <= 1'b0;
            r_pub      <= 2'b00;
        end else if (advance) begin
            r_run_mode <= n_run_mode;
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_dir      <= n_dir;
            r_latched  <= n_latched;
            r_pub      <= n_pub;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_sbyte   <= n_sbyte;
            r_swrite  <= n_swrite;
            r_fbyte   <= n_fbyte;
            r_fwrite  <= n_fwrite;
            r_changed <= n_changed;
            r_event   <= n_event;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_step_port_byte  = r_sbyte;
    assign o_step_port_write = r_swrite;
    assign o_flap_port_byte  = r_fbyte;
    assign o_flap_port_write = r_fwrite;
    assign o_limit_home      = r_pub[0];
    assign o_limit_end       = r_pub[1];
    assign o_limits_changed  = r_changed;
    assign o_is_running      = r_run_mode;
    assign o_event_code      = r_event;

    a_phase_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_SAMPLE) |-> r_run_mode)
        else $error("step phase active while idle");

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipe");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_event)
            && $stable(r_pub) && $stable(r_run_mode)))
        else $error("result or state changed while output stalled");

    a_step_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_swrite) |-> (r_sbyte == 2'b00))
        else $error("step byte nonzero without a write");

    a_flap_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fwrite) |-> (r_event == EV_CLOSED || r_event == EV_IN_OPEN
            || r_event == EV_OUT_OPEN))
        else $error("flap write without a flap event");

endmodule

// File: test/step_dir_pulse_generator_with_limits_unit_tb.sv
`timescale 1ns / 1ps

module step_dir_pulse_generator_with_limits_unit_tb;
    import sdpg_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] status;
        logic       new_dir;
        logic [1:0] flap_sel;
    } t_motor_cmd;

    typedef struct packed {
        logic [1:0] step_byte;
        logic       step_write;
        logic [7:0] flap_byte;
        logic       flap_write;
        logic       home;
        logic       lim_end;
        logic       changed;
        logic       running;
        logic [2:0] ev;
    } t_motor_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [2:0]           cfg_index = REG_HALF_PERIOD;
    logic [CFG_WIDTH-1:0] cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [2:0]           drv_op = OP_TICK;
    logic [7:0]           drv_status = 8'h00;
    logic                 drv_new_dir = 1'b0;
    logic [1:0]           drv_flap_sel = FLAP_CLOSE_BOTH;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           o_step_port_byte;
    logic                 o_step_port_write;
    logic [7:0]           o_flap_port_byte;
    logic                 o_flap_port_write;
    logic                 o_limit_home;
    logic                 o_limit_end;
    logic                 o_limits_changed;
    logic                 o_is_running;
    logic [2:0]           o_event_code;

    step_dir_pulse_generator_with_limits_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_operation       (drv_op),
        .i_status_byte     (drv_status),
        .i_new_direction   (drv_new_dir),
        .i_flap_select     (drv_flap_sel),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_step_port_byte  (o_step_port_byte),
        .o_step_port_write (o_step_port_write),
        .o_flap_port_byte  (o_flap_port_byte),
        .o_flap_port_write (o_flap_port_write),
        .o_limit_home      (o_limit_home),
        .o_limit_end       (o_limit_end),
        .o_limits_changed  (o_limits_changed),
        .o_is_running      (o_is_running),
        .o_event_code      (o_event_code)
    );

    // motor model: configuration copy
    logic [23:0] m_half_period = 24'd1000;
    logic [23:0] m_blocked_wait = 24'd25000;
    logic [2:0]  m_home_bit = 3'd0;
    logic [2:0]  m_end_bit = 3'd1;
    logic [7:0]  m_close_both = 8'h00;
    logic [7:0]  m_open_input = 8'h00;
    logic [7:0]  m_open_output = 8'h00;

    // motor model: state copy
    logic        m_running = 1'b0;
    logic [1:0]  m_phase = PH_SAMPLE;
    logic [23:0] m_count = '0;
    logic        m_dir = 1'b0;
    logic        m_pub_home = 1'b0;
    logic        m_pub_end = 1'b0;
    logic        m_step_dir = 1'b0;

    t_motor_cmd    cmd_queue[$];
    t_motor_result motor_results_due[$];
    t_motor_cmd    drv_cmd;
    t_motor_cmd    mon_cmd;
    t_motor_result mon_want;
    t_motor_result mon_got;

    int  err_count = 0;
    int  cycles = 0;
    int  result_count = 0;
    int  in_gap = 0;
    int  out_gap = 0;
    logic in_xfer = 1'b0;
    logic quiet = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d, %s: got %0d, want %0d", result_count, what, got, want);
        err_count++;
    endtask

    task automatic publish_limits(input logic [7:0] status, inout t_motor_result r);
        logic [7:0] s;
        logic       h;
        logic       e;
        s = status ^ STATUS_INV_MASK;
        h = s[m_home_bit];
        e = s[m_end_bit];
        if (h != m_pub_home || e != m_pub_end) begin
            m_pub_home = h;
            m_pub_end = e;
            r.changed = 1'b1;
        end
    endtask

    task automatic take_sample(input logic [7:0] status, inout t_motor_result r);
        logic blocked;
        publish_limits(status, r);
        blocked = m_dir ? m_pub_home : m_pub_end;
        if (blocked) begin
            m_phase = PH_BLOCKED;
            m_count = m_blocked_wait;
        end else begin
            m_step_dir = m_dir;
            r.step_byte = {m_step_dir, 1'b0};
            r.step_write = 1'b1;
            m_phase = PH_STEP_LOW;
            m_count = m_half_period;
        end
    endtask

    task automatic predict_motor_result(input t_motor_cmd c, output t_motor_result r);
        r = '0;
        case (c.op)
            OP_TICK: begin
                if (m_running) begin
                    if (m_phase == PH_SAMPLE) begin
                        take_sample(c.status, r);
                    end else if (m_count <= 24'd1) begin
                        if (m_phase == PH_STEP_LOW) begin
                            r.step_byte = {m_step_dir, 1'b1};
                            r.step_write = 1'b1;
                            m_phase = PH_STEP_HIGH;
                            m_count = m_half_period;
                        end else begin
                            m_phase = PH_SAMPLE;
                            take_sample(c.status, r);
                        end
                    end else begin
                        m_count = m_count - 24'd1;
                    end
                end
            end
            OP_START: begin
                if (!m_running) begin
                    m_running = 1'b1;
                    m_phase = PH_SAMPLE;
                    m_count = '0;
                    r.ev = EV_STARTED;
                end
            end
            OP_STOP: begin
                if (m_running) begin
                    m_running = 1'b0;
                    m_phase = PH_SAMPLE;
                    m_count = '0;
                    r.ev = EV_STOPPED;
                end
            end
            OP_ABORT: begin
                publish_limits(c.status, r);
                m_running = 1'b0;
                m_phase = PH_SAMPLE;
                m_count = '0;
                r.ev = EV_EMERGENCY;
            end
            OP_SET_DIR: begin
                if (c.new_dir != m_dir) begin
                    m_dir = c.new_dir;
                    r.ev = EV_DIR_CHG;
                end
            end
            OP_SET_FLAPS: begin
                case (c.flap_sel)
                    FLAP_CLOSE_BOTH: begin
                        r.flap_byte = m_close_both;
                        r.flap_write = 1'b1;
                        r.ev = EV_CLOSED;
                    end
                    FLAP_OPEN_IN: begin
                        r.flap_byte = m_open_input;
                        r.flap_write = 1'b1;
                        r.ev = EV_IN_OPEN;
                    end
                    FLAP_OPEN_OUT: begin
                        r.flap_byte = m_open_output;
                        r.flap_write = 1'b1;
                        r.ev = EV_OUT_OPEN;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.home = m_pub_home;
        r.lim_end = m_pub_end;
        r.running = m_running;
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end else if (in_valid && !in_xfer) begin
            // stalled transfer holds its payload
        end else if (in_gap != 0) begin
            in_valid <= 1'b0;
            in_gap <= in_gap - 1;
        end else if (cmd_queue.size() != 0) begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
                in_valid <= 1'b0;
                in_gap <= $urandom_range(0, 10);
            end else begin
                drv_cmd = cmd_queue.pop_front();
                drv_op <= drv_cmd.op;
                drv_status <= drv_cmd.status;
                drv_new_dir <= drv_cmd.new_dir;
                drv_flap_sel <= drv_cmd.flap_sel;
                in_valid <= 1'b1;
            end
        end else begin
            in_valid <= 1'b0;
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        if (!i_rst_n || quiet) begin
            out_stall <= 1'b0;
            out_gap <= 0;
        end else if (out_gap != 0) begin
            out_stall <= 1'b1;
            out_gap <= out_gap - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            out_stall <= 1'b1;
            out_gap <= $urandom_range(0, 10);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end else if (!i_rst_n) begin
            in_xfer <= 1'b0;
        end else begin
            in_xfer <= in_valid && !in_stall;
            if (out_valid && !out_stall) begin
                result_count++;
                mon_got = {o_step_port_byte, o_step_port_write, o_flap_port_byte,
                           o_flap_port_write, o_limit_home, o_limit_end,
                           o_limits_changed, o_is_running, o_event_code};
                if (motor_results_due.size() == 0) begin
                    report_mismatch("result with nothing due", 1, 0);
                end else begin
                    mon_want = motor_results_due.pop_front();
                    if (mon_got.step_byte !== mon_want.step_byte)
                        report_mismatch("step_port_byte", mon_got.step_byte, mon_want.step_byte);
                    if (mon_got.step_write !== mon_want.step_write)
                        report_mismatch("step_port_write", mon_got.step_write,
                                        mon_want.step_write);
                    if (mon_got.flap_byte !== mon_want.flap_byte)
                        report_mismatch("flap_port_byte", mon_got.flap_byte, mon_want.flap_byte);
                    if (mon_got.flap_write !== mon_want.flap_write)
                        report_mismatch("flap_port_write", mon_got.flap_write,
                                        mon_want.flap_write);
                    if (mon_got.home !== mon_want.home)
                        report_mismatch("limit_home", mon_got.home, mon_want.home);
                    if (mon_got.lim_end !== mon_want.lim_end)
                        report_mismatch("limit_end", mon_got.lim_end, mon_want.lim_end);
                    if (mon_got.changed !== mon_want.changed)
                        report_mismatch("limits_changed", mon_got.changed, mon_want.changed);
                    if (mon_got.running !== mon_want.running)
                        report_mismatch("is_running", mon_got.running, mon_want.running);
                    if (mon_got.ev !== mon_want.ev)
                        report_mismatch("event_code", mon_got.ev, mon_want.ev);
                end
            end
            if (in_valid && !in_stall) begin
                mon_cmd = {drv_op, drv_status, drv_new_dir, drv_flap_sel};
                predict_motor_result(mon_cmd, mon_want);
                motor_results_due.insert(motor_results_due.size(), mon_want);
            end
        end
    end

    task automatic push_cmd(input logic [2:0] op, input logic [7:0] status,
                            input logic new_dir, input logic [1:0] flap_sel);
        t_motor_cmd c;
        c = {op, status, new_dir, flap_sel};
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    task automatic wait_drain();
        do @(negedge i_clk);
        while (cmd_queue.size() != 0 || in_valid || motor_results_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_WIDTH-1:0] val);
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            REG_HALF_PERIOD:  m_half_period = val;
            REG_BLOCKED_WAIT: m_blocked_wait = val;
            REG_HOME_BIT:     m_home_bit = val[2:0];
            REG_END_BIT:      m_end_bit = val[2:0];
            REG_CLOSE_BOTH:   m_close_both = val[7:0];
            REG_OPEN_INPUT:   m_open_input = val[7:0];
            REG_OPEN_OUTPUT:  m_open_output = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic setup_motor(input logic [23:0] half, input logic [23:0] wait_ticks,
                               input logic [2:0] hb, input logic [2:0] eb,
                               input logic [7:0] cb, input logic [7:0] oi,
                               input logic [7:0] oo);
        write_reg(REG_HALF_PERIOD, half);
        write_reg(REG_BLOCKED_WAIT, wait_ticks);
        write_reg(REG_HOME_BIT, {21'd0, hb});
        write_reg(REG_END_BIT, {21'd0, eb});
        write_reg(REG_CLOSE_BOTH, {16'd0, cb});
        write_reg(REG_OPEN_INPUT, {16'd0, oi});
        write_reg(REG_OPEN_OUTPUT, {16'd0, oo});
    endtask

    task automatic random_run(input int n);
        int         w;
        logic [2:0] op;
        logic [7:0] s;
        push_cmd(OP_START, 8'h00, 1'b0, FLAP_CLOSE_BOTH);
        for (int k = 0; k < n; k++) begin
            w = $urandom_range(0, 99);
            if (w < 62)      op = OP_TICK;
            else if (w < 68) op = OP_START;
            else if (w < 71) op = OP_STOP;
            else if (w < 74) op = OP_ABORT;
            else if (w < 83) op = OP_SET_DIR;
            else if (w < 91) op = OP_SET_FLAPS;
            else             op = 3'($urandom_range(6, 7));
            // limits mostly clear so the step cycle keeps running
            s = 8'($urandom);
            if ($urandom_range(0, 3) != 0) begin
                s[m_home_bit] = 1'b0;
                s[m_end_bit] = 1'b0;
            end
            push_cmd(op, s ^ STATUS_INV_MASK, 1'($urandom), 2'($urandom_range(0, 3)));
        end
        wait_drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults
        push_cmd(OP_SET_FLAPS, 8'h00, 1'b0, FLAP_CLOSE_BOTH);
        push_cmd(OP_SET_FLAPS, 8'h00, 1'b0, FLAP_OPEN_IN);
        push_cmd(OP_SET_FLAPS, 8'h00, 1'b0, FLAP_OPEN_OUT);
        push_cmd(OP_SET_FLAPS, 8'h00, 1'b0, 2'd3);
        push_cmd(3'd6, 8'hFF, 1'b1, 2'd3);
        push_cmd(3'd7, 8'hFF, 1'b1, 2'd3);
        push_cmd(OP_TICK, 8'h00, 1'b0, FLAP_CLOSE_BOTH);
        push_cmd(OP_STOP, 8'h00, 1'b0, FLAP_CLOSE_BOTH);
        push_cmd(OP_START, 8'h00, 1'b0, FLAP_CLOSE_BOTH);
        push_cmd(OP_START, 8'h00, 1'b0, FLAP_CLOSE_BOTH);
        push_cmd(OP_TICK, 8'h00, 1'b0, FLAP_CLOSE_BOTH);
        push_cmd(OP_TICK, 8'h00, 1'b0, FLAP_CLOSE_BOTH);
        push_cmd(OP_SET_DIR, 8'h00, 1'b1, FLAP_CLOSE_BOTH);
        push_cmd(OP_SET_DIR, 8'h00, 1'b1, FLAP_CLOSE_BOTH);
        push_cmd(OP_ABORT, 8'hFF, 1'b0, FLAP_CLOSE_BOTH);
        push_cmd(OP_STOP, 8'h00, 1'b0, FLAP_CLOSE_BOTH);
        wait_drain();

        // shortest periods, zero wait, home on the inverted bit
        setup_motor(24'd1, 24'd0, 3'd7, 3'd0, 8'hFF, 8'hA5, 8'h5A);
        push_cmd(OP_START, 8'h00, 1'b0, FLAP_CLOSE_BOTH);
        push_cmd(OP_TICK, 8'h00, 1'b0, FLAP_CLOSE_BOTH);
        push_cmd(OP_TICK, 8'h80, 1'b0, FLAP_CLOSE_BOTH);
        push_cmd(OP_TICK, 8'h80, 1'b0, FLAP_CLOSE_BOTH);
        push_cmd(OP_SET_DIR, 8'h00, 1'b0, FLAP_CLOSE_BOTH);
        push_cmd(OP_TICK, 8'h81, 1'b0, FLAP_CLOSE_BOTH);
        push_cmd(OP_TICK, 8'h80, 1'b0, FLAP_CLOSE_BOTH);
        push_cmd(OP_SET_FLAPS, 8'h00, 1'b0, FLAP_CLOSE_BOTH);
        push_cmd(OP_SET_FLAPS, 8'h00, 1'b0, FLAP_OPEN_IN);
        push_cmd(OP_SET_FLAPS, 8'h00, 1'b0, FLAP_OPEN_OUT);
        push_cmd(OP_STOP, 8'h00, 1'b0, FLAP_CLOSE_BOTH);
        wait_drain();

        setup_motor(24'd2, 24'd3, 3'd0, 3'd1, 8'h11, 8'h22, 8'h44);
        random_run(120);
        setup_motor(24'd1, 24'd0, 3'd7, 3'd7, 8'h00, 8'hFF, 8'h00);
        random_run(110);
        setup_motor(24'd3, 24'hFFFFFF, 3'd3, 3'd5, 8'hC3, 8'h3C, 8'h81);
        random_run(60);
        setup_motor(24'hFFFFFF, 24'd1, 3'd2, 3'd6, 8'h7E, 8'h01, 8'h80);
        random_run(50);
        setup_motor(24'd4, 24'd2, 3'd6, 3'd2, 8'hAA, 8'h55, 8'hF0);
        random_run(120);
        quiet = 1'b1;
        setup_motor(24'd1, 24'd1, 3'd4, 3'd0, 8'h0F, 8'hE7, 8'h18);
        random_run(150);

        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/sdpg_pkg.sv
design/sdpg_limits.sv
design/step_dir_pulse_generator_with_limits_unit.sv
test/step_dir_pulse_generator_with_limits_unit_tb.sv
